// ----- rtl/assert_macros.svh -----
// Assertion shorthands used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is active.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ----- rtl/ggaid_pkg.sv -----
package ggaid_pkg;

	localparam int MAX_DIM    = 4096;
	localparam int DIM_W      = 13;
	localparam int PIX_W      = 24;
	localparam int ARC_W      = 27;
	localparam int CNT_W      = 4;
	localparam int DIV_QW     = 12;
	localparam int DIV_STEPS  = 2;
	localparam int DIV_STAGES = DIV_QW / DIV_STEPS;

	// Reciprocal of five for offsets below 2^16.
	localparam logic [16:0] RECIP5    = 17'd52429;
	localparam int          RECIP5_SH = 18;

	// Configuration register indexes.
	localparam logic CFG_WIDTH  = 1'b0;
	localparam logic CFG_HEIGHT = 1'b1;

	// Unit steps of a neighbor offset, two-bit two's complement.
	localparam logic [1:0] D_P = 2'b01;
	localparam logic [1:0] D_Z = 2'b00;
	localparam logic [1:0] D_N = 2'b11;

	typedef enum logic [2:0] {
		RG_CORNER,
		RG_TOP,
		RG_BOT,
		RG_LEFT,
		RG_RIGHT,
		RG_INNER
	} region_t;

	// Grid figures derived from the clamped width and height.
	typedef struct packed {
		logic [DIM_W-1:0] w;
		logic [DIM_W-1:0] h;
		logic [DIM_W-1:0] wm2;
		logic [24:0]      wh;
		logic [PIX_W-1:0] bl;
		logic [ARC_W-1:0] c1;
		logic [ARC_W-1:0] c2;
		logic [ARC_W-1:0] c3;
		logic [ARC_W-1:0] c4;
		logic [ARC_W-1:0] arcs;
	} geom_t;

	// Data that rides alongside the divider.
	typedef struct packed {
		logic             op;
		logic             inv;
		region_t          region;
		logic [ARC_W-1:0] idx;
		logic [11:0]      q5;
		logic [14:0]      offlo;
	} side_t;

	// One finished item: a first result and a count of results.
	typedef struct packed {
		logic [PIX_W-1:0] src;
		logic [PIX_W-1:0] dst;
		logic [ARC_W-1:0] arc;
		logic [CNT_W-1:0] cnt;
		logic             inv;
	} res_t;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] r);
		logic [DIM_W-1:0] v;
		if (r < DIM_W'(2)) begin
			v = DIM_W'(2);
		end else if (r > DIM_W'(MAX_DIM)) begin
			v = DIM_W'(MAX_DIM);
		end else begin
			v = r;
		end
		return v;
	endfunction

	// One restoring division step: {quotient bit, new remainder}.
	function automatic logic [DIM_W:0] div_step(input logic [DIM_W-1:0] rem,
		input logic b, input logic [DIM_W-1:0] den);
		logic [DIM_W:0] t;
		logic [DIM_W:0] r;
		t = {rem, b};
		if (t >= {1'b0, den}) begin
			r = {1'b1, DIM_W'(t - {1'b0, den})};
		end else begin
			r = {1'b0, t[DIM_W-1:0]};
		end
		return r;
	endfunction

	// Neighbor step {dx, dy} of an arc, by region and arc position k.
	function automatic logic [3:0] arc_delta(input region_t rg, input logic [3:0] k);
		logic [3:0] r;
		r = {D_Z, D_Z};
		unique case (rg)
			RG_CORNER: begin
				unique case (k)
					4'd0:    r = {D_P, D_Z};
					4'd1:    r = {D_P, D_P};
					4'd2:    r = {D_Z, D_P};
					4'd3:    r = {D_Z, D_P};
					4'd4:    r = {D_N, D_P};
					4'd5:    r = {D_N, D_Z};
					4'd6:    r = {D_Z, D_N};
					4'd7:    r = {D_P, D_N};
					4'd8:    r = {D_P, D_Z};
					4'd9:    r = {D_Z, D_N};
					4'd10:   r = {D_N, D_Z};
					default: r = {D_N, D_N};
				endcase
			end
			RG_TOP: begin
				unique case (k)
					4'd0:    r = {D_P, D_Z};
					4'd1:    r = {D_P, D_P};
					4'd2:    r = {D_Z, D_P};
					4'd3:    r = {D_N, D_P};
					default: r = {D_N, D_Z};
				endcase
			end
			RG_BOT: begin
				unique case (k)
					4'd0:    r = {D_Z, D_N};
					4'd1:    r = {D_P, D_N};
					4'd2:    r = {D_P, D_Z};
					4'd3:    r = {D_N, D_Z};
					default: r = {D_N, D_N};
				endcase
			end
			RG_LEFT: begin
				unique case (k)
					4'd0:    r = {D_Z, D_N};
					4'd1:    r = {D_P, D_N};
					4'd2:    r = {D_P, D_Z};
					4'd3:    r = {D_P, D_P};
					default: r = {D_Z, D_P};
				endcase
			end
			RG_RIGHT: begin
				unique case (k)
					4'd0:    r = {D_Z, D_N};
					4'd1:    r = {D_Z, D_P};
					4'd2:    r = {D_N, D_N};
					4'd3:    r = {D_N, D_Z};
					default: r = {D_N, D_P};
				endcase
			end
			default: begin
				unique case (k)
					4'd0:    r = {D_Z, D_P};
					4'd1:    r = {D_P, D_N};
					4'd2:    r = {D_P, D_Z};
					4'd3:    r = {D_P, D_P};
					4'd4:    r = {D_Z, D_N};
					4'd5:    r = {D_N, D_N};
					4'd6:    r = {D_N, D_Z};
					default: r = {D_N, D_P};
				endcase
			end
		endcase
		return r;
	endfunction

endpackage

// ----- rtl/ggaid_front.sv -----
module ggaid_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    in_valid,
	input  logic                    in_op,
	input  logic [26:0]             in_index,
	input  ggaid_pkg::geom_t        geom,
	output logic                    out_valid,
	output logic [23:0]             out_num,
	output logic [12:0]             out_den,
	output ggaid_pkg::side_t        out_side
);
	import ggaid_pkg::*;

	logic             v_s1, v_s2, v_s3;
	logic             op_s1, op_s2, op_s3;
	logic [ARC_W-1:0] idx_s1, idx_s2, idx_s3;
	logic             inv_s2, inv_s3;
	region_t          rg_s2, rg_s3;
	logic [ARC_W-1:0] off_s3;

	logic             inv_c;
	region_t          rg_c;
	logic [ARC_W-1:0] rbase_c;
	logic [32:0]      prod5_c;

	// Valid bits travel with the words.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Range check and region of the arc number.
	always_comb begin
		if (op_s1) begin
			inv_c = idx_s1 >= ARC_W'(geom.wh);
		end else begin
			inv_c = idx_s1 >= geom.arcs;
		end
		if (idx_s1 < ARC_W'(12)) begin
			rg_c = RG_CORNER;
		end else if (idx_s1 < geom.c1) begin
			rg_c = RG_TOP;
		end else if (idx_s1 < geom.c2) begin
			rg_c = RG_BOT;
		end else if (idx_s1 < geom.c3) begin
			rg_c = RG_LEFT;
		end else if (idx_s1 < geom.c4) begin
			rg_c = RG_RIGHT;
		end else begin
			rg_c = RG_INNER;
		end
	end

	// First arc number of the region.
	always_comb begin
		unique case (rg_s2)
			RG_CORNER: rbase_c = '0;
			RG_TOP:    rbase_c = ARC_W'(12);
			RG_BOT:    rbase_c = geom.c1;
			RG_LEFT:   rbase_c = geom.c2;
			RG_RIGHT:  rbase_c = geom.c3;
			default:   rbase_c = geom.c4;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1  <= in_op;
			idx_s1 <= in_index;
			op_s2  <= op_s1;
			idx_s2 <= idx_s1;
			inv_s2 <= inv_c;
			rg_s2  <= rg_c;
			op_s3  <= op_s2;
			idx_s3 <= idx_s2;
			inv_s3 <= inv_s2;
			rg_s3  <= rg_s2;
			off_s3 <= idx_s2 - rbase_c;
		end
	end

	// Edge ordinal by reciprocal of five; divider operands.
	assign prod5_c   = 33'(off_s3[15:0]) * 33'(RECIP5);
	assign out_valid = v_s3;
	assign out_num   = op_s3 ? idx_s3[PIX_W-1:0] : off_s3[ARC_W-1:3];
	assign out_den   = op_s3 ? geom.w : geom.wm2;

	always_comb begin
		out_side.op     = op_s3;
		out_side.inv    = inv_s3;
		out_side.region = rg_s3;
		out_side.idx    = idx_s3;
		out_side.q5     = prod5_c[RECIP5_SH+11:RECIP5_SH];
		out_side.offlo  = off_s3[14:0];
	end

endmodule

// ----- rtl/ggaid_div.sv -----
module ggaid_div (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    in_valid,
	input  logic [23:0]             num,
	input  logic [12:0]             den,
	input  ggaid_pkg::side_t        in_side,
	output logic                    out_valid,
	output logic [11:0]             quot,
	output logic [12:0]             rem,
	output ggaid_pkg::side_t        out_side
);
	import ggaid_pkg::*;

	// Stage registers, one entry per divider stage.
	logic              v_s    [DIV_STAGES];
	logic [DIM_W-1:0]  rem_s  [DIV_STAGES];
	logic [DIV_QW-1:0] nb_s   [DIV_STAGES];
	logic [DIV_QW-1:0] q_s    [DIV_STAGES];
	logic [DIM_W-1:0]  den_s  [DIV_STAGES];
	side_t             side_s [DIV_STAGES];

	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
		logic              v_in;
		logic [DIM_W-1:0]  r_in, d_in, r_o;
		logic [DIV_QW-1:0] nb_in, q_in, nb_o, q_o;
		side_t             sd_in;
		logic [DIM_W:0]    st;

		if (g == 0) begin : g_first
			assign v_in  = in_valid;
			assign r_in  = DIM_W'(num[23:DIV_QW]);
			assign nb_in = num[DIV_QW-1:0];
			assign q_in  = '0;
			assign d_in  = den;
			assign sd_in = in_side;
		end else begin : g_next
			assign v_in  = v_s[g-1];
			assign r_in  = rem_s[g-1];
			assign nb_in = nb_s[g-1];
			assign q_in  = q_s[g-1];
			assign d_in  = den_s[g-1];
			assign sd_in = side_s[g-1];
		end

		// Two quotient bits per stage.
		always_comb begin
			r_o  = r_in;
			q_o  = q_in;
			nb_o = nb_in;
			st   = '0;
			for (int j = 0; j < DIV_STEPS; j++) begin
				st   = div_step(r_o, nb_o[DIV_QW-1], d_in);
				r_o  = st[DIM_W-1:0];
				q_o  = {q_o[DIV_QW-2:0], st[DIM_W]};
				nb_o = {nb_o[DIV_QW-2:0], 1'b0};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g] <= 1'b0;
			end else if (en) begin
				v_s[g] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g]  <= r_o;
				nb_s[g]   <= nb_o;
				q_s[g]    <= q_o;
				den_s[g]  <= d_in;
				side_s[g] <= sd_in;
			end
		end
	end

	assign out_valid = v_s[DIV_STAGES-1];
	assign quot      = q_s[DIV_STAGES-1];
	assign rem       = rem_s[DIV_STAGES-1];
	assign out_side  = side_s[DIV_STAGES-1];

endmodule

// ----- rtl/ggaid_back.sv -----
module ggaid_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    in_valid,
	input  logic [11:0]             quot,
	input  logic [12:0]             rem,
	input  ggaid_pkg::side_t        in_side,
	input  ggaid_pkg::geom_t        geom,
	output logic                    out_valid,
	output ggaid_pkg::res_t         out_res
);
	import ggaid_pkg::*;

	// Stage 1 registers.
	logic             v_s1, op_s1, inv_s1;
	region_t          rg_s1;
	logic [ARC_W-1:0] idx_s1;
	logic [3:0]       k_s1;
	logic [11:0]      q5_s1;
	logic [DIM_W-1:0] x_s1;
	logic [11:0]      y_s1;
	logic             x0_s1, xl_s1, y0_s1, yl_s1;
	logic [PIX_W-1:0] prod_s1;
	// Stage 2 registers.
	logic             v_s2, zd_s2;
	logic [PIX_W-1:0] o_s2;
	logic [14:0]      dl_s2;
	res_t             r_s2;
	// Stage 3 register.
	logic             v_s3;
	res_t             r_s3;

	logic [14:0]      m5_c;
	logic [2:0]       k5_c;
	logic [3:0]       k_c;
	logic [DIM_W-1:0] ma_c, mb_c;
	logic [25:0]      prod_c;

	logic [PIX_W-1:0] o_c;
	logic [3:0]       dd_c;
	logic [14:0]      dyw_c, dl_c;
	logic [DIM_W-1:0] xm1_c, ym1_c;
	logic [ARC_W-1:0] x5_c, y5_c, base_c;
	logic [CNT_W-1:0] n_c;
	res_t             r_c;
	logic             zd_c;
	res_t             r3_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Arc position in its pixel and the one shared multiply.
	always_comb begin
		m5_c = 15'({in_side.q5, 2'b00}) + 15'(in_side.q5);
		k5_c = 3'(in_side.offlo - m5_c);
		unique case (in_side.region)
			RG_CORNER: k_c = in_side.idx[3:0];
			RG_INNER:  k_c = {1'b0, in_side.offlo[2:0]};
			default:   k_c = {1'b0, k5_c};
		endcase
		if (in_side.op) begin
			ma_c = DIM_W'(quot) - DIM_W'(1);
			mb_c = geom.wm2;
		end else if (in_side.region == RG_INNER) begin
			ma_c = DIM_W'(quot) + DIM_W'(1);
			mb_c = geom.w;
		end else begin
			ma_c = DIM_W'(in_side.q5) + DIM_W'(1);
			mb_c = geom.w;
		end
		prod_c = 26'(ma_c) * 26'(mb_c);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1   <= in_side.op;
			inv_s1  <= in_side.inv;
			rg_s1   <= in_side.region;
			idx_s1  <= in_side.idx;
			k_s1    <= k_c;
			q5_s1   <= in_side.q5;
			x_s1    <= rem;
			y_s1    <= quot;
			x0_s1   <= rem == '0;
			xl_s1   <= rem == geom.w - DIM_W'(1);
			y0_s1   <= quot == '0;
			yl_s1   <= DIM_W'(quot) == geom.h - DIM_W'(1);
			prod_s1 <= prod_c[PIX_W-1:0];
		end
	end

	// Source pixel and step of a decoded arc.
	always_comb begin
		unique case (rg_s1)
			RG_CORNER: begin
				unique case (k_s1) inside
					4'd0, 4'd1, 4'd2: o_c = '0;
					4'd3, 4'd4, 4'd5: o_c = PIX_W'(geom.w) - PIX_W'(1);
					4'd6, 4'd7, 4'd8: o_c = geom.bl;
					default:          o_c = PIX_W'(geom.wh - 25'd1);
				endcase
			end
			RG_TOP:   o_c = PIX_W'(q5_s1) + PIX_W'(1);
			RG_BOT:   o_c = geom.bl + PIX_W'(q5_s1) + PIX_W'(1);
			RG_LEFT:  o_c = prod_s1;
			RG_RIGHT: o_c = prod_s1 + PIX_W'(geom.w) - PIX_W'(1);
			default:  o_c = prod_s1 + PIX_W'(x_s1) + PIX_W'(1);
		endcase
		dd_c = arc_delta(rg_s1, k_s1);
		unique case (dd_c[1:0])
			D_P:     dyw_c = 15'(geom.w);
			D_N:     dyw_c = 15'd0 - 15'(geom.w);
			default: dyw_c = '0;
		endcase
		dl_c = 15'({{13{dd_c[3]}}, dd_c[3:2]}) + dyw_c;
	end

	// First outgoing arc number and arc count of a queried pixel.
	always_comb begin
		xm1_c = x_s1 - DIM_W'(1);
		ym1_c = DIM_W'(y_s1) - DIM_W'(1);
		x5_c  = ARC_W'({xm1_c, 2'b00}) + ARC_W'(xm1_c);
		y5_c  = ARC_W'({ym1_c, 2'b00}) + ARC_W'(ym1_c);
		n_c   = CNT_W'(5);
		if (y0_s1) begin
			if (x0_s1) begin
				base_c = '0;
				n_c    = CNT_W'(3);
			end else if (xl_s1) begin
				base_c = ARC_W'(3);
				n_c    = CNT_W'(3);
			end else begin
				base_c = ARC_W'(12) + x5_c;
			end
		end else if (yl_s1) begin
			if (x0_s1) begin
				base_c = ARC_W'(6);
				n_c    = CNT_W'(3);
			end else if (xl_s1) begin
				base_c = ARC_W'(9);
				n_c    = CNT_W'(3);
			end else begin
				base_c = geom.c1 + x5_c;
			end
		end else if (x0_s1) begin
			base_c = geom.c2 + y5_c;
		end else if (xl_s1) begin
			base_c = geom.c3 + y5_c;
		end else begin
			base_c = geom.c4 + ARC_W'({PIX_W'(prod_s1 + PIX_W'(xm1_c)), 3'b000});
			n_c    = CNT_W'(8);
		end
	end

	// Choose the word for the operation; out of range gives one flagged result.
	always_comb begin
		r_c.dst = '0;
		if (inv_s1) begin
			r_c.src = '0;
			r_c.arc = idx_s1;
			r_c.cnt = CNT_W'(1);
			r_c.inv = 1'b1;
			zd_c    = 1'b1;
		end else if (op_s1) begin
			r_c.src = idx_s1[PIX_W-1:0];
			r_c.arc = base_c;
			r_c.cnt = n_c;
			r_c.inv = 1'b0;
			zd_c    = 1'b1;
		end else begin
			r_c.src = o_c;
			r_c.arc = idx_s1;
			r_c.cnt = CNT_W'(1);
			r_c.inv = 1'b0;
			zd_c    = 1'b0;
		end
	end

	// Destination pixel: the source plus the signed step.
	always_comb begin
		r3_c = r_s2;
		if (zd_s2) begin
			r3_c.dst = '0;
		end else begin
			r3_c.dst = PIX_W'(o_s2 + PIX_W'({{9{dl_s2[14]}}, dl_s2}));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			o_s2  <= o_c;
			dl_s2 <= dl_c;
			zd_s2 <= zd_c;
			r_s2  <= r_c;
			r_s3  <= r3_c;
		end
	end

	assign out_valid = v_s3;
	assign out_res   = r_s3;

endmodule

// ----- rtl/ggaid_seq.sv -----
module ggaid_seq (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  ggaid_pkg::res_t         in_res,
	output logic                    take,
	output logic                    done,
	output logic [23:0]             src_pixel,
	output logic [23:0]             dst_pixel,
	output logic [26:0]             arc_number,
	output logic                    last,
	output logic                    invalid
);
	import ggaid_pkg::*;

	logic act_q;
	res_t cur_q;

	// A new word is loaded when idle or on the final result of a burst.
	assign take = !act_q || (cur_q.cnt == CNT_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
		end else if (take) begin
			act_q <= in_valid;
		end
	end

	// Walk the arc numbers of a burst one per cycle.
	always_ff @(posedge clk) begin
		if (take) begin
			cur_q <= in_res;
		end else begin
			cur_q.arc <= cur_q.arc + ARC_W'(1);
			cur_q.cnt <= cur_q.cnt - CNT_W'(1);
		end
	end

	assign done       = act_q;
	assign src_pixel  = cur_q.src;
	assign dst_pixel  = cur_q.dst;
	assign arc_number = cur_q.arc;
	assign last       = cur_q.cnt == CNT_W'(1);
	assign invalid    = cur_q.inv;

endmodule

// ----- rtl/grid_graph_arc_index_decode_top.sv -----
// Channel   Handshake          Words
// config    cfg_we             cfg_addr, cfg_wdata
// command   start, busy        op, index
// result    done (strobe)      src_pixel, dst_pixel, arc_number, last, invalid
//
// A command is taken when start is high and busy is low; its first result
// passes 3 decode, 6 divider and 3 assembly stages and the result register.
// An arc decode gives one result and a pixel query 3, 5 or 8, one per cycle,
// and the single result port paces the commands: busy holds the whole
// pipeline while a burst is still being sent. Reset clears all valid bits
// and sets both grid sizes to 2; the derived grid figures are registered
// from the configuration registers.
module grid_graph_arc_index_decode_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_addr,
	input  logic [12:0] cfg_wdata,
	input  logic        start,
	input  logic        op,
	input  logic [26:0] index,
	output logic        busy,
	output logic        done,
	output logic [23:0] src_pixel,
	output logic [23:0] dst_pixel,
	output logic [26:0] arc_number,
	output logic        last,
	output logic        invalid
);
	import ggaid_pkg::*;

	logic [DIM_W-1:0] wcfg_q, hcfg_q;
	geom_t            geom_d, geom_q;

	logic [DIM_W-1:0] hm2_c;
	logic [14:0]      ew_c, eh_c;
	logic [25:0]      inner_c, wh_c, bl_c;

	logic             en;
	logic             f_valid, d_valid, b_valid, take;
	logic [23:0]      f_num;
	logic [12:0]      f_den;
	side_t            f_side, d_side;
	logic [11:0]      d_quot;
	logic [12:0]      d_rem;
	res_t             b_res;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wcfg_q <= DIM_W'(2);
			hcfg_q <= DIM_W'(2);
		end else if (cfg_we) begin
			unique case (cfg_addr)
				CFG_WIDTH:  wcfg_q <= cfg_wdata;
				default:    hcfg_q <= cfg_wdata;
			endcase
		end
	end

	// Grid figures: region bounds of the arc numbering.
	always_comb begin
		geom_d.w    = clamp_dim(wcfg_q);
		geom_d.h    = clamp_dim(hcfg_q);
		geom_d.wm2  = geom_d.w - DIM_W'(2);
		hm2_c       = geom_d.h - DIM_W'(2);
		ew_c        = 15'({geom_d.wm2, 2'b00}) + 15'(geom_d.wm2);
		eh_c        = 15'({hm2_c, 2'b00}) + 15'(hm2_c);
		inner_c     = 26'(geom_d.wm2) * 26'(hm2_c);
		wh_c        = 26'(geom_d.w) * 26'(geom_d.h);
		bl_c        = 26'(geom_d.w) * 26'(geom_d.h - DIM_W'(1));
		geom_d.wh   = wh_c[24:0];
		geom_d.bl   = bl_c[PIX_W-1:0];
		geom_d.c1   = ARC_W'(12) + ARC_W'(ew_c);
		geom_d.c2   = geom_d.c1 + ARC_W'(ew_c);
		geom_d.c3   = geom_d.c2 + ARC_W'(eh_c);
		geom_d.c4   = geom_d.c3 + ARC_W'(eh_c);
		geom_d.arcs = geom_d.c4 + ARC_W'({inner_c[23:0], 3'b000});
	end

	always_ff @(posedge clk) begin
		geom_q <= geom_d;
	end

	// The pipeline moves unless its last word waits on a burst.
	assign en   = !b_valid || take;
	assign busy = !en;

	ggaid_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (start && !busy),
		.in_op     (op),
		.in_index  (index),
		.geom      (geom_q),
		.out_valid (f_valid),
		.out_num   (f_num),
		.out_den   (f_den),
		.out_side  (f_side)
	);

	ggaid_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (f_valid),
		.num       (f_num),
		.den       (f_den),
		.in_side   (f_side),
		.out_valid (d_valid),
		.quot      (d_quot),
		.rem       (d_rem),
		.out_side  (d_side)
	);

	ggaid_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (d_valid),
		.quot      (d_quot),
		.rem       (d_rem),
		.in_side   (d_side),
		.geom      (geom_q),
		.out_valid (b_valid),
		.out_res   (b_res)
	);

	ggaid_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (b_valid),
		.in_res     (b_res),
		.take       (take),
		.done       (done),
		.src_pixel  (src_pixel),
		.dst_pixel  (dst_pixel),
		.arc_number (arc_number),
		.last       (last),
		.invalid    (invalid)
	);

endmodule

// ----- rtl/ggaid_chk.sv -----
`include "assert_macros.svh"

module ggaid_chk (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        busy,
	input  logic        done,
	input  logic [23:0] src_pixel,
	input  logic [26:0] arc_number,
	input  logic        last,
	input  logic        invalid
);

	// A burst runs without gaps until its last word.
	`ASSERT_NEXT(a_burst_continues, clk, arst_n, done && !last, done)
	// Arcs of one pixel share the source and count up by one.
	`ASSERT_NEXT(a_burst_src_held, clk, arst_n, done && !last, src_pixel == $past(src_pixel))
	`ASSERT_NEXT(a_burst_arc_step, clk, arst_n, done && !last,
		arc_number == 27'($past(arc_number) + 27'd1))
	// An out-of-range command gives a single word.
	`ASSERT_NOW(a_invalid_single, clk, arst_n, done && invalid, last)
	// Commands are only held off while a burst has more words to send.
	`ASSERT_NOW(a_busy_in_burst, clk, arst_n, busy, done && !last)

endmodule

bind grid_graph_arc_index_decode_top ggaid_chk u_chk (.*);
